>>> src/utf8_string_validator_assert.svh
// Assertion macros for the UTF-8 string validator.
// Used by the top level only; no other dependencies.
`ifndef UTF8_STRING_VALIDATOR_ASSERT_SVH
`define UTF8_STRING_VALIDATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define UTF8V_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define UTF8V_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UTF8V_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define UTF8V_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/utf8v_pkg.sv
// Shared types and byte constants for the UTF-8 string validator.
// No dependencies.
package utf8v_pkg;

  localparam logic [7:0] BYTE_TAB      = 8'h09;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_PRINT_LO = 8'h20;
  localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;
  localparam logic [7:0] LEAD2_LO      = 8'hC2;
  localparam logic [7:0] LEAD2_HI      = 8'hDF;
  localparam logic [7:0] LEAD_E0       = 8'hE0;
  localparam logic [7:0] LEAD_ED       = 8'hED;
  localparam logic [7:0] LEAD3_HI      = 8'hEF;
  localparam logic [7:0] LEAD_F0       = 8'hF0;
  localparam logic [7:0] LEAD_F3       = 8'hF3;
  localparam logic [7:0] LEAD_F4       = 8'hF4;
  localparam logic [7:0] CONT_LO       = 8'h80;
  localparam logic [7:0] CONT_HI       = 8'hBF;
  localparam logic [7:0] CONT_8F       = 8'h8F;
  localparam logic [7:0] CONT_90       = 8'h90;
  localparam logic [7:0] CONT_9F       = 8'h9F;
  localparam logic [7:0] CONT_A0       = 8'hA0;

  typedef enum logic [2:0] {
    RANGE_FULL  = 3'd0,
    RANGE_A0_BF = 3'd1,
    RANGE_80_9F = 3'd2,
    RANGE_90_BF = 3'd3,
    RANGE_80_8F = 3'd4
  } range_class_t;

  typedef struct packed {
    logic [1:0]   pending;
    range_class_t range_class;
    logic         error;
  } state_t;

  // valid here means the request advances into the decoder this cycle
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       end_marker;
  } item_t;

  typedef struct packed {
    logic valid;
    logic string_valid;
  } result_t;

endpackage

>>> src/utf8_string_validator.sv
// Top level of the restricted UTF-8 string validator.
// Depends on utf8v_pkg, utf8v_in_stage, utf8v_decode, utf8v_out_stage and the assert header.
//
//  channel  ports                                      request
//  in       in_valid in_stall in_data_byte in_end_marker  one string byte or an end marker
//  out      out_valid out_stall out_string_valid        one verdict per end marker
//
// One request per cycle is accepted while in_stall is low; a byte is checked in the cycle after it is taken.
// An end marker's verdict passes the input register and then the result register before it is valid at out.
// in_stall rises only while an end marker waits for the result register to be taken.
// Reset (synchronous, rst_n low) clears the sequence state and both valid flags.
`include "utf8_string_validator_assert.svh"
module utf8_string_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_marker,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_string_valid
);

  utf8v_pkg::item_t   dec_item;
  utf8v_pkg::result_t dec_res;
  utf8v_pkg::state_t  dec_st;
  logic               out_free;
  logic               out_blocked;
  logic               end_taken;
  logic               err_byte;
  logic               st_idle;

  utf8v_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_end_marker(in_end_marker),
    .out_free     (out_free),
    .item         (dec_item)
  );

  utf8v_decode u_dec (
    .clk  (clk),
    .rst_n(rst_n),
    .item (dec_item),
    .res  (dec_res),
    .st   (dec_st)
  );

  utf8v_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (dec_res),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_string_valid(out_string_valid)
  );

  assign out_blocked = out_valid && out_stall;
  assign end_taken   = dec_item.valid && dec_item.end_marker;
  assign err_byte    = dec_st.error && dec_item.valid && !dec_item.end_marker;
  assign st_idle     = (dec_st.pending == 2'd0) && !dec_st.error &&
                       (dec_st.range_class == utf8v_pkg::RANGE_FULL);

  `UTF8V_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_blocked, "stray input stall")
  `UTF8V_ASSERT_IMP(a_res_room, clk, rst_n, dec_res.valid, out_free, "result with no room")
  `UTF8V_ASSERT_NXT(a_end_clears, clk, rst_n, end_taken, st_idle, "state kept after end")
  `UTF8V_ASSERT_NXT(a_err_sticky, clk, rst_n, err_byte, $stable(dec_st), "error not sticky")

endmodule

>>> src/utf8v_in_stage.sv
// Input register and input-side handshake for the UTF-8 string validator.
// Depends on utf8v_pkg.
module utf8v_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_end_marker,
  input  logic            out_free,
  output utf8v_pkg::item_t item
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_data_r;
  logic       s1_end_r;
  logic       go;
  logic       accept;

  // data bytes always move on; an end marker needs room for its result
  assign go       = s1_valid_r && (!s1_end_r || out_free);
  assign in_stall = s1_valid_r && !go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data_byte;
      s1_end_r  <= in_end_marker;
    end
  end

  assign item.valid      = go;
  assign item.data_byte  = s1_data_r;
  assign item.end_marker = s1_end_r;

endmodule

>>> src/utf8v_decode.sv
// Sequence state and per-byte check/update for the UTF-8 string validator.
// Depends on utf8v_pkg.
module utf8v_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  utf8v_pkg::item_t   item,
  output utf8v_pkg::result_t res,
  output utf8v_pkg::state_t  st
);

  utf8v_pkg::state_t st_r;
  utf8v_pkg::state_t st_nxt;

  function automatic logic cont_ok(input logic [7:0] b, input utf8v_pkg::range_class_t cls);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = utf8v_pkg::CONT_LO;
    hi = utf8v_pkg::CONT_HI;
    case (cls)
      utf8v_pkg::RANGE_A0_BF: lo = utf8v_pkg::CONT_A0;
      utf8v_pkg::RANGE_80_9F: hi = utf8v_pkg::CONT_9F;
      utf8v_pkg::RANGE_90_BF: lo = utf8v_pkg::CONT_90;
      utf8v_pkg::RANGE_80_8F: hi = utf8v_pkg::CONT_8F;
      default: ;
    endcase
    return (b >= lo) && (b <= hi);
  endfunction

  always_comb begin
    logic [7:0] b;
    b                = item.data_byte;
    st_nxt           = st_r;
    res.valid        = 1'b0;
    res.string_valid = 1'b0;
    if (item.valid) begin
      if (item.end_marker) begin
        res.valid          = 1'b1;
        res.string_valid   = !st_r.error && (st_r.pending == 2'd0);
        st_nxt.pending     = 2'd0;
        st_nxt.range_class = utf8v_pkg::RANGE_FULL;
        st_nxt.error       = 1'b0;
      end else if (!st_r.error) begin
        if (st_r.pending != 2'd0) begin
          if (cont_ok(b, st_r.range_class)) begin
            st_nxt.pending     = st_r.pending - 2'd1;
            st_nxt.range_class = utf8v_pkg::RANGE_FULL;
          end else begin
            st_nxt.error = 1'b1;
          end
        end else if (b == utf8v_pkg::BYTE_TAB || b == utf8v_pkg::BYTE_LF ||
                     b == utf8v_pkg::BYTE_CR ||
                     (b >= utf8v_pkg::BYTE_PRINT_LO && b <= utf8v_pkg::BYTE_PRINT_HI)) begin
          st_nxt = st_r;
        end else if (b >= utf8v_pkg::LEAD2_LO && b <= utf8v_pkg::LEAD2_HI) begin
          st_nxt.pending     = 2'd1;
          st_nxt.range_class = utf8v_pkg::RANGE_FULL;
        end else if (b == utf8v_pkg::LEAD_E0) begin
          st_nxt.pending     = 2'd2;
          st_nxt.range_class = utf8v_pkg::RANGE_A0_BF;
        end else if (b == utf8v_pkg::LEAD_ED) begin
          // surrogates excluded
          st_nxt.pending     = 2'd2;
          st_nxt.range_class = utf8v_pkg::RANGE_80_9F;
        end else if (b > utf8v_pkg::LEAD_E0 && b <= utf8v_pkg::LEAD3_HI) begin
          st_nxt.pending     = 2'd2;
          st_nxt.range_class = utf8v_pkg::RANGE_FULL;
        end else if (b == utf8v_pkg::LEAD_F0) begin
          st_nxt.pending     = 2'd3;
          st_nxt.range_class = utf8v_pkg::RANGE_90_BF;
        end else if (b > utf8v_pkg::LEAD_F0 && b <= utf8v_pkg::LEAD_F3) begin
          st_nxt.pending     = 2'd3;
          st_nxt.range_class = utf8v_pkg::RANGE_FULL;
        end else if (b == utf8v_pkg::LEAD_F4) begin
          // caps code points at U+10FFFF
          st_nxt.pending     = 2'd3;
          st_nxt.range_class = utf8v_pkg::RANGE_80_8F;
        end else begin
          st_nxt.error = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.pending     <= 2'd0;
      st_r.range_class <= utf8v_pkg::RANGE_FULL;
      st_r.error       <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

>>> src/utf8v_out_stage.sv
// Result register and output-side handshake for the UTF-8 string validator.
// Depends on utf8v_pkg.
module utf8v_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  utf8v_pkg::result_t res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_string_valid
);

  logic out_valid_r;
  logic out_valid_nxt;
  logic out_sv_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_sv_r <= res.string_valid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_string_valid = out_sv_r;

endmodule

>>> dv/utf8_string_validator_tb.sv
// Self-checking testbench for utf8_string_validator: directed strings, then random ones.
// Depends on utf8v_pkg and the RTL under src; predicts each verdict in the testbench itself.
`timescale 1ns / 100ps

module utf8_string_validator_tb;

  localparam int RAND_ITEMS  = 550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_marker = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_string_valid;

  utf8_string_validator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_marker    (in_end_marker),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_string_valid (out_string_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state, mirrors the decoder
  logic [1:0]              pend_cnt = 2'd0;
  utf8v_pkg::range_class_t next_cls = utf8v_pkg::RANGE_FULL;
  logic                    err_flag = 1'b0;

  logic         verdict_q[$];
  logic [7:0]   str_q[$];

  int fail_cnt      = 0;
  int items_sent    = 0;
  int strings_sent  = 0;
  int verdicts_seen = 0;
  int valid_seen    = 0;
  int cycle_cnt     = 0;
  int burst_left    = 0;
  bit sender_low    = 1'b1;

  function automatic bit cont_ok(logic [7:0] b, utf8v_pkg::range_class_t cls);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = utf8v_pkg::CONT_LO;
    hi = utf8v_pkg::CONT_HI;
    case (cls)
      utf8v_pkg::RANGE_A0_BF: lo = utf8v_pkg::CONT_A0;
      utf8v_pkg::RANGE_80_9F: hi = utf8v_pkg::CONT_9F;
      utf8v_pkg::RANGE_90_BF: lo = utf8v_pkg::CONT_90;
      utf8v_pkg::RANGE_80_8F: hi = utf8v_pkg::CONT_8F;
      default: ;
    endcase
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic bit single_ok(logic [7:0] b);
    return (b == utf8v_pkg::BYTE_TAB) || (b == utf8v_pkg::BYTE_LF) ||
           (b == utf8v_pkg::BYTE_CR) ||
           ((b >= utf8v_pkg::BYTE_PRINT_LO) && (b <= utf8v_pkg::BYTE_PRINT_HI));
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    if (err_flag) return;
    if (pend_cnt != 2'd0) begin
      if (cont_ok(b, next_cls)) begin
        pend_cnt = pend_cnt - 2'd1;
        next_cls = utf8v_pkg::RANGE_FULL;
      end else begin
        err_flag = 1'b1;
      end
      return;
    end
    if (single_ok(b)) return;
    if ((b >= utf8v_pkg::LEAD2_LO) && (b <= utf8v_pkg::LEAD2_HI)) begin
      pend_cnt = 2'd1;
      next_cls = utf8v_pkg::RANGE_FULL;
    end else if (b == utf8v_pkg::LEAD_E0) begin
      pend_cnt = 2'd2;
      next_cls = utf8v_pkg::RANGE_A0_BF;
    end else if (b == utf8v_pkg::LEAD_ED) begin
      pend_cnt = 2'd2;
      next_cls = utf8v_pkg::RANGE_80_9F;
    end else if ((b > utf8v_pkg::LEAD_E0) && (b <= utf8v_pkg::LEAD3_HI)) begin
      pend_cnt = 2'd2;
      next_cls = utf8v_pkg::RANGE_FULL;
    end else if (b == utf8v_pkg::LEAD_F0) begin
      pend_cnt = 2'd3;
      next_cls = utf8v_pkg::RANGE_90_BF;
    end else if ((b > utf8v_pkg::LEAD_F0) && (b <= utf8v_pkg::LEAD_F3)) begin
      pend_cnt = 2'd3;
      next_cls = utf8v_pkg::RANGE_FULL;
    end else if (b == utf8v_pkg::LEAD_F4) begin
      pend_cnt = 2'd3;
      next_cls = utf8v_pkg::RANGE_80_8F;
    end else begin
      err_flag = 1'b1;
    end
  endfunction

  function automatic void predict_end();
    verdict_q.push_back(!err_flag && (pend_cnt == 2'd0));
    pend_cnt = 2'd0;
    next_cls = utf8v_pkg::RANGE_FULL;
    err_flag = 1'b0;
  endfunction

  // Sends one request and returns once it is taken and any gap after it is over; bursts and gaps live here.
  task automatic send_req(input logic [7:0] b, input logic em);
    int gap;
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_end_marker <= em;
    sender_low = 1'b0;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (em) begin
      strings_sent++;
      predict_end();
    end else begin
      predict_byte(b);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(30, 0);
      gap = $urandom_range(6, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        sender_low = 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_string();
    foreach (str_q[i]) send_req(str_q[i], 1'b0);
    send_req(8'($urandom_range(255, 0)), 1'b1);
  endtask

  task automatic drain_results();
    if (!sender_low) begin
      in_valid <= 1'b0;
      sender_low = 1'b1;
    end
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // biased toward the ends of the range
  function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi);
    case ($urandom_range(3, 0))
      0: return lo;
      1: return hi;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [7:0] cont_pick(utf8v_pkg::range_class_t cls);
    case (cls)
      utf8v_pkg::RANGE_A0_BF: return pick(utf8v_pkg::CONT_A0, utf8v_pkg::CONT_HI);
      utf8v_pkg::RANGE_80_9F: return pick(utf8v_pkg::CONT_LO, utf8v_pkg::CONT_9F);
      utf8v_pkg::RANGE_90_BF: return pick(utf8v_pkg::CONT_90, utf8v_pkg::CONT_HI);
      utf8v_pkg::RANGE_80_8F: return pick(utf8v_pkg::CONT_LO, utf8v_pkg::CONT_8F);
      default:                return pick(utf8v_pkg::CONT_LO, utf8v_pkg::CONT_HI);
    endcase
  endfunction

  function automatic utf8v_pkg::range_class_t lead_class(logic [7:0] lead);
    case (lead)
      utf8v_pkg::LEAD_E0: return utf8v_pkg::RANGE_A0_BF;
      utf8v_pkg::LEAD_ED: return utf8v_pkg::RANGE_80_9F;
      utf8v_pkg::LEAD_F0: return utf8v_pkg::RANGE_90_BF;
      utf8v_pkg::LEAD_F4: return utf8v_pkg::RANGE_80_8F;
      default:            return utf8v_pkg::RANGE_FULL;
    endcase
  endfunction

  function automatic void push_code_point();
    logic [7:0]              lead;
    utf8v_pkg::range_class_t cls;
    int                      kind;
    kind = $urandom_range(9, 0);
    if (kind < 4) begin
      case ($urandom_range(7, 0))
        0: str_q.push_back(utf8v_pkg::BYTE_TAB);
        1: str_q.push_back(utf8v_pkg::BYTE_LF);
        2: str_q.push_back(utf8v_pkg::BYTE_CR);
        default: str_q.push_back(pick(utf8v_pkg::BYTE_PRINT_LO, utf8v_pkg::BYTE_PRINT_HI));
      endcase
    end else if (kind < 6) begin
      str_q.push_back(pick(utf8v_pkg::LEAD2_LO, utf8v_pkg::LEAD2_HI));
      str_q.push_back(cont_pick(utf8v_pkg::RANGE_FULL));
    end else if (kind < 8) begin
      case ($urandom_range(3, 0))
        0: lead = utf8v_pkg::LEAD_E0;
        1: lead = utf8v_pkg::LEAD_ED;
        default: lead = pick(utf8v_pkg::LEAD_E0 + 8'd1, utf8v_pkg::LEAD3_HI);
      endcase
      cls = lead_class(lead);
      str_q.push_back(lead);
      str_q.push_back(cont_pick(cls));
      str_q.push_back(cont_pick(utf8v_pkg::RANGE_FULL));
    end else begin
      case ($urandom_range(3, 0))
        0: lead = utf8v_pkg::LEAD_F0;
        1: lead = utf8v_pkg::LEAD_F4;
        default: lead = pick(utf8v_pkg::LEAD_F0 + 8'd1, utf8v_pkg::LEAD_F3);
      endcase
      cls = lead_class(lead);
      str_q.push_back(lead);
      str_q.push_back(cont_pick(cls));
      str_q.push_back(cont_pick(utf8v_pkg::RANGE_FULL));
      str_q.push_back(cont_pick(utf8v_pkg::RANGE_FULL));
    end
  endfunction

  task automatic test_single_bytes();
    str_q = {};
    send_string();                                  // empty string
    str_q = {utf8v_pkg::BYTE_TAB, utf8v_pkg::BYTE_LF, utf8v_pkg::BYTE_CR,
             utf8v_pkg::BYTE_PRINT_LO, utf8v_pkg::BYTE_PRINT_HI};
    send_string();
    str_q = {8'h00};                                // zero byte is just a bad byte
    send_string();
    str_q = {8'hFF};
    send_string();
  endtask

  task automatic test_multibyte();
    str_q = {utf8v_pkg::LEAD_E0, utf8v_pkg::CONT_A0, utf8v_pkg::CONT_LO,
             utf8v_pkg::LEAD_ED, utf8v_pkg::CONT_9F, utf8v_pkg::CONT_HI,
             utf8v_pkg::LEAD_F0, utf8v_pkg::CONT_90, utf8v_pkg::CONT_LO, utf8v_pkg::CONT_LO,
             utf8v_pkg::LEAD_F4, utf8v_pkg::CONT_8F, utf8v_pkg::CONT_HI, utf8v_pkg::CONT_HI};
    send_string();
    // error stays set over a good byte
    str_q = {utf8v_pkg::LEAD_F4, utf8v_pkg::CONT_90, 8'h41};
    send_string();
    str_q = {utf8v_pkg::LEAD_E0 + 8'd1, utf8v_pkg::CONT_LO};  // truncated
    send_string();
  endtask

  task automatic test_random_strings();
    int sel;
    int n;
    int idx;
    bit paused;
    paused = 1'b0;
    while (items_sent < RAND_ITEMS) begin
      str_q = {};
      sel = $urandom_range(9, 0);
      if (sel < 7) begin
        n = $urandom_range(8, 0);
        repeat (n) push_code_point();
        if ((str_q.size() != 0) && ($urandom_range(3, 0) == 0)) begin
          idx = $urandom_range(str_q.size() - 1, 0);
          if ($urandom_range(1, 0)) str_q[idx] = 8'($urandom_range(255, 0));
          else void'(str_q.pop_back());
        end
      end else begin
        n = $urandom_range(10, 1);
        repeat (n) begin
          if ($urandom_range(1, 0)) str_q.push_back(8'($urandom_range(255, 0)));
          else str_q.push_back(8'($urandom_range(255, 128)));
        end
      end
      send_string();
      if (!paused && (items_sent > RAND_ITEMS / 2)) begin
        paused = 1'b1;
        drain_results();
      end
    end
  endtask

  // receiver stalls in phases: none, light, heavy
  int       rx_phase_left = 0;
  int       rx_mode = 0;
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       <= $urandom_range(2, 0);
      rx_phase_left <= $urandom_range(60, 10);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(3, 0) == 0);
      default: out_stall <= 1'($urandom_range(1, 0));
    endcase
  end

  always @(posedge clk) begin
    logic exp_v;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      if (out_string_valid === 1'b1) valid_seen++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual string_valid=%0b",
                 $time, out_string_valid);
        fail_cnt++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_string_valid !== exp_v) begin
          $display("%0t: string_valid mismatch, expected %0b actual %0b",
                   $time, exp_v, out_string_valid);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, verdict_q.size());
      $display("utf8_string_validator_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_bytes();
    drain_results();
    test_multibyte();
    drain_results();
    test_random_strings();
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d requests in %0d strings; checked %0d verdicts (%0d valid).",
             items_sent, strings_sent, verdicts_seen, valid_seen);
    $display("Mismatches or unexpected results: %0d", fail_cnt);
    if (fail_cnt == 0) begin
      $display("utf8_string_validator_tb OK");
    end else begin
      $display("utf8_string_validator_tb NOT OK");
    end
    $finish;
  end

endmodule
